### src/mfts_pkg.sv
package mfts_pkg;

  localparam int NumTasks   = 24;
  localparam int NumLevels  = 4;
  localparam int TaskW      = 5;
  localparam int LevelW     = $clog2(NumLevels);

  localparam logic [TaskW-1:0] NullLink = 5'd31;

  typedef enum logic {
    OpAdd      = 1'b0,
    OpDispatch = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [LevelW-1:0] level;
    logic [TaskW-1:0]  task_req;
  } item_t;

  typedef struct packed {
    logic [TaskW-1:0]  granted_task;
    logic              granted;
    logic              add_accepted;
    logic [LevelW-1:0] served_level;
    logic              wake_idle;
  } result_t;

endpackage

### src/mfts_pick.sv
module mfts_pick import mfts_pkg::*; (
  input  logic [NumLevels-1:0] head_ok_i,
  input  logic [LevelW-1:0]    scan_i,
  output logic                 found_o,
  output logic [LevelW-1:0]    level_o
);

  // first non-empty level at or after the scan start
  always_comb begin
    found_o = 1'b0;
    level_o = '0;
    for (int l = NumLevels - 1; l >= 0; l--) begin
      if (head_ok_i[l] && (LevelW'(l) >= scan_i)) begin
        found_o = 1'b1;
        level_o = LevelW'(l);
      end
    end
  end

endmodule

### src/mfts_core.sv
module mfts_core import mfts_pkg::*; #(
  parameter int NUM_TASKS  = NumTasks
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam int TidxW = $clog2(NUM_TASKS);
  localparam logic [LevelW-1:0] Lowest  = LevelW'(NumLevels - 1);
  localparam logic [TaskW-1:0]  TaskLim = TaskW'(NUM_TASKS);

  logic [TaskW-1:0] link_q [NUM_TASKS];
  logic [TaskW-1:0] link_d [NUM_TASKS];
  logic [NUM_TASKS-1:0] pend_q, pend_d;
  logic [TaskW-1:0] head_q [NumLevels];
  logic [TaskW-1:0] head_d [NumLevels];
  logic [TaskW-1:0] tail_q [NumLevels];
  logic [TaskW-1:0] tail_d [NumLevels];
  logic [LevelW-1:0] scan_q, scan_d;
  logic [LevelW-1:0] cur_q, cur_d;

  logic [NumLevels-1:0] head_ok;
  logic                 found;
  logic [LevelW-1:0]    pick_lvl;

  logic              lv_ok, task_ok;
  logic [LevelW-1:0] lidx;
  logic [TidxW-1:0]  tidx;
  logic [TaskW-1:0]  tl;
  logic              tl_ok, lhead_ok;
  logic [TaskW-1:0]  pop_t, nx;
  logic [TidxW-1:0]  pop_idx;
  logic              nx_ok;

  logic             acc, wake, gnt;
  logic [TaskW-1:0] gtask;

  always_comb begin
    for (int l = 0; l < NumLevels; l++) begin
      head_ok[l] = head_q[l] < TaskLim;
    end
  end

  mfts_pick u_pick (
    .head_ok_i(head_ok),
    .scan_i   (scan_q),
    .found_o  (found),
    .level_o  (pick_lvl)
  );

  assign lv_ok    = 32'(item_i.level) < NumLevels;
  assign task_ok  = item_i.task_req < TaskLim;
  assign lidx     = item_i.level;
  assign tidx     = item_i.task_req[TidxW-1:0];
  assign tl       = tail_q[lidx];
  assign tl_ok    = tl < TaskLim;
  assign lhead_ok = head_q[lidx] < TaskLim;
  assign pop_t    = head_q[pick_lvl];
  assign pop_idx  = pop_t[TidxW-1:0];
  assign nx       = link_q[pop_idx];
  assign nx_ok    = nx < TaskLim;

  always_comb begin
    link_d = link_q;
    pend_d = pend_q;
    head_d = head_q;
    tail_d = tail_q;
    scan_d = scan_q;
    cur_d  = cur_q;
    acc    = 1'b0;
    wake   = 1'b0;
    gnt    = 1'b0;
    gtask  = '0;
    if (item_i.op == OpAdd) begin
      if (lv_ok && task_ok) begin
        if (!pend_q[tidx]) begin
          pend_d[tidx] = 1'b1;
          link_d[tidx] = NullLink;
          if (!tl_ok || !lhead_ok) begin
            head_d[lidx] = item_i.task_req;
          end else begin
            link_d[tl[TidxW-1:0]] = item_i.task_req;
          end
          tail_d[lidx] = item_i.task_req;
          if (lidx < scan_q) begin
            scan_d = lidx;
          end
          acc = 1'b1;
        end
        if ((lidx != Lowest) && (cur_q == Lowest)) begin
          wake = 1'b1;
        end
      end
    end else begin
      if (found) begin
        scan_d          = pick_lvl;
        cur_d           = pick_lvl;
        pend_d[pop_idx] = 1'b0;
        if (!nx_ok) begin
          head_d[pick_lvl] = NullLink;
          tail_d[pick_lvl] = NullLink;
        end else begin
          head_d[pick_lvl] = nx;
        end
        link_d[pop_idx] = NullLink;
        gtask           = pop_t;
        gnt             = 1'b1;
      end else begin
        scan_d = Lowest;
        cur_d  = Lowest;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        link_q[i] <= NullLink;
      end
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l] <= NullLink;
        tail_q[l] <= NullLink;
      end
      pend_q <= '0;
      scan_q <= '0;
      cur_q  <= '0;
    end else if (fire_i) begin
      link_q <= link_d;
      head_q <= head_d;
      tail_q <= tail_d;
      pend_q <= pend_d;
      scan_q <= scan_d;
      cur_q  <= cur_d;
    end
  end

  assign result_o.granted_task = gtask;
  assign result_o.granted      = gnt;
  assign result_o.add_accepted = acc;
  assign result_o.served_level = cur_d;
  assign result_o.wake_idle    = wake;

endmodule

### src/multilevel_fifo_task_scheduler.sv
// Strict-priority task scheduler, one linked FIFO per level. Takes one beat
// per clock while in_stall_o is low and returns exactly one result beat per
// input beat. An input beat is first registered; when it leaves the input
// stage the add or dispatch is applied to the head/tail pointers, the
// pending flags and the next-link table in a single update and its result
// is registered at the output. A stalled output beat holds the input stage,
// so at most two beats are in flight.
module multilevel_fifo_task_scheduler import mfts_pkg::*; #(
  parameter int NUM_TASKS  = NumTasks
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [LevelW-1:0] level_i,
  input  logic [TaskW-1:0]  task_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TaskW-1:0]  granted_task_o,
  output logic              granted_o,
  output logic              add_accepted_o,
  output logic [LevelW-1:0] served_level_o,
  output logic              wake_idle_o
);

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t core_res;
  logic    out_free, s1_adv, s1_load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_item_q.op       <= op_e'(operation_i);
      s1_item_q.level    <= level_i;
      s1_item_q.task_req <= task_req_i;
    end
    if (s1_adv) begin
      out_q <= core_res;
    end
  end

  mfts_core #(
    .NUM_TASKS (NUM_TASKS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_adv),
    .item_i  (s1_item_q),
    .result_o(core_res)
  );

  assign out_valid_o    = out_valid_q;
  assign granted_task_o = out_q.granted_task;
  assign granted_o      = out_q.granted;
  assign add_accepted_o = out_q.add_accepted;
  assign served_level_o = out_q.served_level;
  assign wake_idle_o    = out_q.wake_idle;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output can drain");

  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced beat did not reach output");

  a_grant_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> (!add_accepted_o && !wake_idle_o))
    else $error("dispatch result carries add flags");

  a_add_no_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && add_accepted_o) |-> (!granted_o && (granted_task_o == '0)))
    else $error("add result carries a granted task");

endmodule
